>>> design/est_pkg.sv
`timescale 1ns / 1ps

package est_pkg;

   // Sample rate and tone arithmetic.
   localparam int SAMPLE_RATE_HZ = 16000;
   localparam int MS_PER_S       = 1000;
   localparam int SAMPLES_PER_MS = SAMPLE_RATE_HZ / MS_PER_S;
   localparam int PEAK           = 32767;
   localparam int VOL_FULL       = 255;
   localparam int ATTACK_DIV     = 20;
   localparam int RELEASE_MUL    = 5;
   localparam int RELEASE_START  = 4;

   // Field and register widths.
   localparam int SAMPLE_W    = 16;
   localparam int HALF_W      = SAMPLE_W - 1;
   localparam int FREQ_W      = 13;
   localparam int DUR_W       = 16;
   localparam int VOL_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 8;

   localparam int TOTAL_W  = $clog2((2 ** DUR_W - 1) * SAMPLES_PER_MS + 1);
   localparam int PHASE_W  = $clog2(SAMPLE_RATE_HZ);

   // Envelope: Q1.16 with unity as 2^16.
   localparam int ENV_FRAC_W = 16;
   localparam int ENV_W      = ENV_FRAC_W + 1;
   localparam int ENV_CNT_W  = $clog2(ENV_FRAC_W + 1);

   // Sine table: quarter wave, full cycle of four quadrants.
   localparam int SINE_ROM_DEPTH = 1024;
   localparam int ROM_AW         = $clog2(SINE_ROM_DEPTH);
   localparam int IDX_W          = ROM_AW + 2;
   localparam int CYCLE_POINTS   = 4 * SINE_ROM_DEPTH;
   localparam int TAYLOR_TERMS   = 12;
   localparam int ROM_BLOCK      = 32;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Table index = floor(phase * CYCLE_POINTS / SAMPLE_RATE_HZ), taken as a
   // multiply by a rounded-up reciprocal. The error stays below one step of
   // the exact fraction because 2^IDX_SHIFT exceeds the square of the rate.
   localparam int IDX_SHIFT = 2 * PHASE_W + 1;
   localparam logic [63:0] IDX_RECIP =
      ((64'(CYCLE_POINTS) << IDX_SHIFT) + 64'(SAMPLE_RATE_HZ) - 64'd1)
      / 64'(SAMPLE_RATE_HZ);
   localparam int IDX_MUL_W = PHASE_W + 32;

   // Amplitude = floor(PEAK * volume / VOL_FULL), same reciprocal scheme.
   localparam int AMP_SHIFT = 2 * VOL_W;
   localparam logic [63:0] AMP_RECIP =
      ((64'(PEAK) << AMP_SHIFT) + 64'(VOL_FULL) - 64'd1) / 64'(VOL_FULL);
   localparam int AMP_MUL_W = VOL_W + 32;

   localparam int PROD_W = 2 * HALF_W;
   localparam int NORM_W = PROD_W + ENV_W;

   // Register reset values.
   localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);
   localparam logic [DUR_W-1:0]  DUR_RESET  = DUR_W'(100);
   localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(80);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TONE_FREQ     = 2'd0,
      CSR_TONE_DURATION = 2'd1,
      CSR_TONE_VOLUME   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_SCALE,
      ST_NORM,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [ENV_FRAC_W-1:0] quotient;
   } env_div_status_type;

   typedef struct packed {
      logic              negate;
      logic [HALF_W-1:0] magnitude;
   } sine_read_type;

   typedef logic [SAMPLE_W-1:0] rom_type [SINE_ROM_DEPTH];

   // Unsigned quotient by shift and subtract, used while the table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] numer,
                                          input logic [63:0] denom);
      logic [63:0] quot;
      logic [64:0] rem;
      quot = '0;
      rem  = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], numer[i]};
         if (rem >= {1'b0, denom}) begin
            rem     = rem - {1'b0, denom};
            quot[i] = 1'b1;
         end
      end
      return quot;
   endfunction

   // Entry k = round(PEAK * sin(pi/2 * k / depth)) from a Q2.30 Taylor series.
   function automatic rom_type build_quarter_sine();
      rom_type            rom;
      logic [63:0]        x;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] acc;
      int                 k;
      for (int blk = 0; blk < SINE_ROM_DEPTH / ROM_BLOCK; blk++) begin
         for (int j = 0; j < ROM_BLOCK; j++) begin
            k    = blk * ROM_BLOCK + j;
            x    = (HALF_PI_Q30 * 64'(k)) >> ROM_AW;
            term = x;
            acc  = signed'(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
               term = (term * x) >> 30;
               term = (term * x) >> 30;
               term = udiv64(term, 64'(2 * n) * 64'(2 * n + 1));
               if (n % 2 == 1) begin
                  acc = acc - signed'(term);
               end else begin
                  acc = acc + signed'(term);
               end
            end
            if (acc < 0) begin
               acc = 64'sd0;
            end
            v = (unsigned'(acc) * 64'(PEAK) + (64'd1 << 29)) >> 30;
            if (v > 64'(PEAK)) begin
               v = 64'(PEAK);
            end
            rom[k] = v[SAMPLE_W-1:0];
         end
      end
      return rom;
   endfunction

endpackage

>>> design/est_sine_lookup.sv
`timescale 1ns / 1ps

module est_sine_lookup (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [est_pkg::PHASE_W-1:0]  phase,
   output est_pkg::sine_read_type       sine
);
   import est_pkg::*;

   localparam rom_type ROM_CONTENT = build_quarter_sine();

   logic [IDX_MUL_W-1:0] idx_full;
   logic [IDX_W-1:0]     idx;
   logic [1:0]           quad;
   logic [ROM_AW-1:0]    offset;
   logic [ROM_AW-1:0]    addr;

   logic [SAMPLE_W-1:0]  rom_rd_ff;
   logic                 peak_ff;
   logic                 negate_ff;

   assign idx_full = IDX_MUL_W'(phase) * IDX_MUL_W'(IDX_RECIP);
   assign idx      = IDX_W'(idx_full >> IDX_SHIFT);
   assign quad     = idx[IDX_W-1 -: 2];
   assign offset   = idx[ROM_AW-1:0];

   // Odd quadrants run the quarter wave backwards; their first point is the peak.
   assign addr = quad[0] ? ROM_AW'(~offset + ROM_AW'(1)) : offset;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rom_rd_ff <= ROM_CONTENT[addr];
         peak_ff   <= quad[0] && (offset == '0);
         negate_ff <= quad[1];
      end
   end

   assign sine.negate    = negate_ff;
   assign sine.magnitude = peak_ff ? HALF_W'(PEAK) : rom_rd_ff[HALF_W-1:0];

endmodule

>>> design/est_env_div.sv
`timescale 1ns / 1ps

module est_env_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [est_pkg::TOTAL_W-1:0]  numer,
   input  logic [est_pkg::TOTAL_W-1:0]  denom,
   output est_pkg::env_div_status_type  status
);
   import est_pkg::*;

   // Restoring division of numer * 2^16 by denom, one quotient bit a cycle.
   // The numerator is always below the divisor, so the quotient fits 16 bits.

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ENV_CNT_W-1:0]  count_ff, count_in;
   logic [TOTAL_W-1:0]    rem_ff, rem_in;
   logic [TOTAL_W-1:0]    den_ff, den_in;
   logic [ENV_FRAC_W-1:0] quot_ff, quot_in;
   logic [TOTAL_W:0]      shifted;
   logic                  fits;

   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = numer;
         den_in   = denom;
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? TOTAL_W'(shifted - {1'b0, den_ff}) : shifted[TOTAL_W-1:0];
         quot_in  = {quot_ff[ENV_FRAC_W-2:0], fits};
         count_in = count_ff + ENV_CNT_W'(1);
         if (count_ff == ENV_CNT_W'(ENV_FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule

>>> design/enveloped_sine_tone_generator.sv
`timescale 1ns / 1ps

// Sine tone generator with a linear attack and release envelope.
// Each word taken on the req_ channel is one sample tick; bit 0 of req_tdata
// is the restart flag, which starts the tone over at sample zero and phase
// zero. Every tick gives exactly one word on the rsp_ channel: the signed
// sample in rsp_tdata, rsp_tlast on the final sample of the tone and rsp_tuser
// high while the sample belongs to a running tone (an idle tick gives zeros).
// Frequency, length in milliseconds and volume are written through the csr_
// channel, which is always ready; write them only while no tick is in flight.
// An idle tick goes straight to the result register. A tick of a running
// tone reads the sine table through its register and works out the
// amplitude, waits on the serial envelope divider on the attack and release
// ramps only, then takes two multiplies before the result register loads;
// the next tick is taken once the generator is back in idle.
// req_tready is high only between ticks. The result sits in an output
// register, so a new tick is accepted while rsp_tvalid waits on rsp_tready;
// a finished tick then holds in its last step until that register frees up.
// Reset loads the default registers (1000 Hz, 100 ms, volume 80), clears the
// tone position and phase and leaves the generator idle.
module enveloped_sine_tone_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick channel. req_tdata: [0] restart, [7:1] zero.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [est_pkg::REQ_DATA_W-1:0]       req_tdata,
   // Sample channel. rsp_tdata: [15:0] sample. rsp_tuser: [0] active.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [est_pkg::SAMPLE_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [est_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [est_pkg::CSR_DATA_W-1:0]       csr_data
);
   import est_pkg::*;

   localparam int ATT_W = TOTAL_W + 5;
   localparam int REL_W = TOTAL_W + 3;

   // Configuration registers.
   logic [FREQ_W-1:0] freq_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [VOL_W-1:0]  vol_ff;

   // Tone state and sequencer.
   state_type          state_ff, state_in;
   logic [TOTAL_W-1:0] pos_ff, pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               running_ff, running_in;
   logic               live_ff, live_in;

   // Datapath registers.
   logic [ENV_W-1:0]  env_ff, env_in;
   logic [HALF_W-1:0] amp_ff, amp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] norm_ff, norm_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_active_ff, rsp_active_in;

   logic               restart;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] pos_start;
   logic [TOTAL_W-1:0] pos_inc;
   logic               attack;
   logic               release_ramp;
   logic [TOTAL_W-1:0] div_numer;
   logic               div_start;
   logic               rom_rd_en;
   logic               slot_free;
   logic               last_now;
   logic [AMP_MUL_W-1:0] amp_full;
   logic [NORM_W-1:0]    norm_full;
   logic [PHASE_W:0]     phase_sum;
   logic [PHASE_W-1:0]   phase_next;
   logic [HALF_W-1:0]    fold_hi;
   logic [HALF_W-1:0]    fold_lo;
   logic [HALF_W:0]      fold_sum;
   logic [HALF_W-1:0]    mag;
   logic [SAMPLE_W-1:0]  mag_ext;

   env_div_status_type div_status;
   sine_read_type      sine;

   assign restart   = req_tdata[0];
   assign total     = TOTAL_W'(TOTAL_W'(dur_ff) * TOTAL_W'(SAMPLES_PER_MS));
   assign pos_start = restart ? '0 : pos_ff;
   assign pos_inc   = pos_ff + TOTAL_W'(1);
   assign last_now  = pos_inc == total;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Envelope regions: attack while 20n < total, release while 5n > 4 total.
   assign attack       = ATT_W'(pos_ff) * ATT_W'(ATTACK_DIV) < ATT_W'(total);
   assign release_ramp = REL_W'(pos_ff) * REL_W'(RELEASE_MUL)
                         > REL_W'(total) * REL_W'(RELEASE_START);
   assign div_numer = attack
      ? TOTAL_W'(ATT_W'(pos_ff) * ATT_W'(ATTACK_DIV))
      : TOTAL_W'(REL_W'(total - pos_ff) * REL_W'(RELEASE_MUL));

   assign amp_full  = AMP_MUL_W'(vol_ff) * AMP_MUL_W'(AMP_RECIP);
   assign norm_full = NORM_W'(prod_ff) * NORM_W'(env_ff);

   assign phase_sum  = (PHASE_W + 1)'(phase_ff) + (PHASE_W + 1)'(freq_ff);
   assign phase_next = (phase_sum >= (PHASE_W + 1)'(SAMPLE_RATE_HZ))
      ? PHASE_W'(phase_sum - (PHASE_W + 1)'(SAMPLE_RATE_HZ))
      : PHASE_W'(phase_sum);

   // Division by the peak, which is 2^15 - 1: with y = hi * 2^15 + lo,
   // y / PEAK = hi + (hi + lo) / PEAK, and hi + lo stays below twice the peak.
   assign fold_hi  = norm_ff[PROD_W-1:HALF_W];
   assign fold_lo  = norm_ff[HALF_W-1:0];
   assign fold_sum = (HALF_W + 1)'(fold_hi) + (HALF_W + 1)'(fold_lo);
   assign mag      = fold_hi + HALF_W'(fold_sum >= (HALF_W + 1)'(PEAK));
   assign mag_ext  = SAMPLE_W'(mag);

   est_sine_lookup u_sine (
      .clock (clock),
      .rd_en (rom_rd_en),
      .phase (phase_ff),
      .sine  (sine)
   );

   est_env_div u_env_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_numer),
      .denom  (total),
      .status (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      running_in    = running_ff;
      live_in       = live_ff;
      env_in        = env_ff;
      amp_in        = amp_ff;
      prod_in       = prod_ff;
      norm_in       = norm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_active_in = rsp_active_ff;
      rom_rd_en     = 1'b0;
      div_start     = 1'b0;
      req_tready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // A tone runs while its position is still short of its length.
               pos_in     = pos_start;
               phase_in   = restart ? '0 : phase_ff;
               live_in    = (restart || running_ff) && (pos_start < total);
               running_in = live_in;
               state_in   = live_in ? ST_SETUP : ST_RESULT;
            end
         end
         ST_SETUP: begin
            rom_rd_en = 1'b1;
            amp_in    = HALF_W'(amp_full >> AMP_SHIFT);
            if (attack || release_ramp) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               env_in   = ENV_W'(1) << ENV_FRAC_W;
               state_in = ST_SCALE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               env_in   = ENV_W'(div_status.quotient);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = PROD_W'(sine.magnitude) * PROD_W'(amp_ff);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            norm_in  = norm_full[PROD_W+ENV_FRAC_W-1:ENV_FRAC_W];
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (live_ff) begin
                  rsp_sample_in = sine.negate ? SAMPLE_W'(-mag_ext) : mag_ext;
                  rsp_last_in   = last_now;
                  rsp_active_in = 1'b1;
                  pos_in        = pos_inc;
                  phase_in      = phase_next;
                  running_in    = pos_inc < total;
               end else begin
                  rsp_sample_in = '0;
                  rsp_last_in   = 1'b0;
                  rsp_active_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         phase_ff     <= '0;
         running_ff   <= 1'b0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      env_in_reg: begin
         env_ff        <= env_in;
         amp_ff        <= amp_in;
         prod_ff       <= prod_in;
         norm_ff       <= norm_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_active_ff <= rsp_active_in;
      end
   end

   // Register writes; an index past the last register is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         dur_ff  <= DUR_RESET;
         vol_ff  <= VOL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TONE_FREQ:     freq_ff <= csr_data[FREQ_W-1:0];
            CSR_TONE_DURATION: dur_ff  <= csr_data[DUR_W-1:0];
            CSR_TONE_VOLUME:   vol_ff  <= csr_data[VOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = signed'(rsp_sample_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_active_ff;

   // An idle word carries no sample and never closes a tone.
   a_idle_word_is_silent : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("idle result word carries a sample or a last flag");

   // The phase accumulator wraps below the sample rate.
   a_phase_in_range : assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(SAMPLE_RATE_HZ))
      else $error("phase accumulator out of range");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_divide : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIVIDE)
      else $error("envelope divider finished outside the divide step");

   // The final sample of a tone stops it.
   a_last_stops_tone : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && slot_free && live_ff && last_now
      |=> !running_ff && rsp_tvalid && rsp_tlast)
      else $error("tone kept running after its last sample");

endmodule
